>>> src/mfcw_pkg.sv
// shared types and constants for the modular frame check word block
`default_nettype none

package mfcw_pkg;

   // divider step counter
   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] LONG_LAST  = STEP_CNT_W'(23);
   localparam logic [STEP_CNT_W-1:0] SHORT_LAST = STEP_CNT_W'(7);

   // zero bytes folded in after the last byte of a frame
   localparam logic [1:0] TAIL_FOLDS = 2'd2;

   // controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_STEP = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // start a fold
      logic from_part;  // fold a zero byte into the partial remainder
      logic step;       // one restoring subtract step
      logic commit;     // store the partial remainder as the running remainder
      logic emit;       // load the result register and clear the remainder
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic long_fold;  // source remainder not below the divisor: full 24 steps
      logic out_free;   // result register can take a new word
   } sts_type;

endpackage

`default_nettype wire

>>> src/modular_frame_check_word.sv
// top level of the modular frame check word block
//
//  channel  ports                                   direction
//  req      req_valid req_ready req_data_byte req_last_byte   in
//  rsp      rsp_valid rsp_ready rsp_check_word      out
//  csr      csr_valid csr_ready csr_divisor         in
//
// a byte takes a short fold when the running remainder is below the divisor and a long
// one otherwise, run by the bit-serial restoring modulo unit (one subtract per cycle).
// a last byte adds two zero-byte folds (long ones with a zero divisor) before the check
// word is sent.
// one request is handled at a time; the result register lets the next request in
// while a check word waits. a full result register stalls only the next last byte.
// synchronous reset sets the divisor to 1 and clears the remainder.
`default_nettype none

module modular_frame_check_word (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_check_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_divisor
);

   mfcw_pkg::cmd_type cmd;
   mfcw_pkg::sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   mfcw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_byte (req_last_byte),
      .sts           (sts),
      .cmd           (cmd)
   );

   mfcw_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_divisor    (csr_divisor),
      .req_data_byte  (req_data_byte),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_check_word (rsp_check_word)
   );

endmodule

`default_nettype wire

>>> src/mfcw_dp.sv
// datapath: divisor register, running remainder, bit-serial modulo unit, result register
`default_nettype none

module mfcw_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [15:0]      csr_divisor,
   input  wire logic [7:0]       req_data_byte,
   input  wire mfcw_pkg::cmd_type cmd,
   output mfcw_pkg::sts_type     sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [15:0]           rsp_check_word
);

   logic [15:0] div_ff, div_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] part_ff, part_in;
   logic [23:0] sh_ff, sh_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] word_ff, word_in;

   logic [15:0] src_rem;
   logic [7:0]  src_byte;
   logic        long_fold;
   logic [16:0] trial;
   logic [16:0] trial_sub;
   logic        div_zero;
   logic [15:0] final_rem;
   logic [15:0] diff;

   // fold source: a request byte onto the running remainder, or a zero byte onto the partial
   always_comb begin
      src_rem   = cmd.from_part ? part_ff : rem_ff;
      src_byte  = cmd.from_part ? 8'h00 : req_data_byte;
      long_fold = (src_rem >= div_ff);
      div_zero  = (div_ff == 16'h0000);
      trial     = {part_ff, sh_ff[23]};
      trial_sub = trial - {1'b0, div_ff};
      final_rem = div_zero ? 16'h0000 : part_ff;
      diff      = (final_rem != 16'h0000) ? (div_ff - final_rem) : 16'h0000;
   end

   // next values
   always_comb begin
      div_in       = csr_valid ? csr_divisor : div_ff;
      rem_in       = rem_ff;
      part_in      = part_ff;
      sh_in        = sh_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      word_in      = word_ff;

      if (cmd.load) begin
         if (long_fold) begin
            part_in = 16'h0000;
            sh_in   = {src_rem, src_byte};
         end else begin
            part_in = src_rem;
            sh_in   = {src_byte, 16'h0000};
         end
      end else if (cmd.step) begin
         part_in = (trial >= {1'b0, div_ff}) ? trial_sub[15:0] : trial[15:0];
         sh_in   = {sh_ff[22:0], 1'b0};
      end

      if (cmd.commit) begin
         rem_in = final_rem;
      end

      // byte-swapped check word
      if (cmd.emit) begin
         rem_in       = 16'h0000;
         rsp_valid_in = 1'b1;
         word_in      = {diff[7:0], diff[15:8]};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= 16'h0001;
         rem_ff       <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_ff       <= div_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      part_ff <= part_in;
      sh_ff   <= sh_in;
      word_ff <= word_in;
   end

   always_comb begin
      sts.long_fold  = long_fold;
      sts.out_free   = ~rsp_valid_ff | rsp_ready;
      rsp_valid      = rsp_valid_ff;
      rsp_check_word = word_ff;
   end

endmodule

`default_nettype wire

>>> src/mfcw_ctrl.sv
// controller: sequences the folds and subtract steps of one request
`default_nettype none

module mfcw_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_last_byte,
   input  wire mfcw_pkg::sts_type sts,
   output mfcw_pkg::cmd_type     cmd
);

   mfcw_pkg::state_type state_ff, state_in;
   logic [mfcw_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] folds_ff, folds_in;
   logic       last_ff, last_in;
   logic       accept;
   logic [mfcw_pkg::STEP_CNT_W-1:0] start_cnt;

   always_comb begin
      req_ready = (state_ff == mfcw_pkg::ST_IDLE);
      accept    = req_valid & req_ready;
      start_cnt = sts.long_fold ? mfcw_pkg::LONG_LAST : mfcw_pkg::SHORT_LAST;
   end

   // state machine
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      folds_in = folds_ff;
      last_in  = last_ff;
      cmd      = '0;

      case (state_ff)
         mfcw_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               cnt_in   = start_cnt;
               last_in  = req_last_byte;
               folds_in = req_last_byte ? mfcw_pkg::TAIL_FOLDS : 2'd0;
               state_in = mfcw_pkg::ST_STEP;
            end
         end
         mfcw_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = (folds_ff != 2'd0) ? mfcw_pkg::ST_LOAD : mfcw_pkg::ST_FIN;
            end
         end
         mfcw_pkg::ST_LOAD: begin
            cmd.load      = 1'b1;
            cmd.from_part = 1'b1;
            cnt_in        = start_cnt;
            folds_in      = folds_ff - 1'b1;
            state_in      = mfcw_pkg::ST_STEP;
         end
         mfcw_pkg::ST_FIN: begin
            // store the remainder, or wait for room and send the check word
            if (!last_ff) begin
               cmd.commit = 1'b1;
               state_in   = mfcw_pkg::ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = mfcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfcw_pkg::ST_IDLE;
         cnt_ff   <= '0;
         folds_ff <= 2'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         folds_ff <= folds_in;
         last_ff  <= last_in;
      end
   end

endmodule

`default_nettype wire
